FILE: src/assert_macros.svh
// assertion macros for the rtl file that checks itself, alpha_transparency_classifier_core
// no dependencies; expects clk and arst_n in the including scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/atc_pkg.sv
// shared types, constants and helpers of the alpha transparency classifier
// no dependencies
package atc_pkg;

	localparam int ALPHA_W = 8;
	localparam int CNT_W   = 21;
	localparam int PROD_W  = 32;

	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	// class codes
	localparam logic [1:0] CLASS_OPAQUE = 2'd0;
	localparam logic [1:0] CLASS_BINARY = 2'd1;
	localparam logic [1:0] CLASS_VARIED = 2'd2;

	// register indexes (word address bit 2)
	localparam logic REG_OPAQUE_THR = 1'b0;
	localparam logic REG_CLEAR_THR  = 1'b1;

	localparam logic [ALPHA_W-1:0] OPAQUE_THR_RESET = 8'd250;
	localparam logic [ALPHA_W-1:0] CLEAR_THR_RESET  = 8'd5;

	typedef struct packed {
		logic [CNT_W-1:0] opaque;
		logic [CNT_W-1:0] clear;
		logic [CNT_W-1:0] partial;
		logic [CNT_W-1:0] total;
	} counts_t;

	// counts of a finished texture, handed to the classifier
	typedef struct packed {
		logic    valid;
		counts_t counts;
	} snap_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
		return (c == CNT_MAX) ? CNT_MAX : c + 1'b1;
	endfunction

endpackage

FILE: src/atc_count.sv
// pixel input register and saturating counters; snapshots counts on the last pixel
// depends on atc_pkg
module atc_count import atc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  logic [ALPHA_W-1:0] pixel_alpha,
	input  logic               last_pixel,
	input  logic [ALPHA_W-1:0] opaque_thr,
	input  logic [ALPHA_W-1:0] clear_thr,
	output snap_t              snap
);

	logic               valid_s1;
	logic [ALPHA_W-1:0] alpha_s1;
	logic               last_s1;
	counts_t            cnt_q;
	counts_t            cnt_next;
	logic               is_op;
	logic               is_cl;
	logic               snap_valid_s2;
	counts_t            snap_cnt_s2;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			alpha_s1 <= pixel_alpha;
			last_s1  <= last_pixel;
		end
	end

	// pixel classification and counter increment
	always_comb begin
		is_op = alpha_s1 >= opaque_thr;
		is_cl = alpha_s1 <= clear_thr;
		cnt_next         = cnt_q;
		cnt_next.total   = sat_inc(cnt_q.total);
		if (is_op) cnt_next.opaque = sat_inc(cnt_q.opaque);
		if (is_cl) cnt_next.clear  = sat_inc(cnt_q.clear);
		if (!is_op && !is_cl) cnt_next.partial = sat_inc(cnt_q.partial);
	end

	// counters clear after the last pixel of a texture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (valid_s1) begin
			cnt_q <= last_s1 ? '0 : cnt_next;
		end
	end

	// snapshot of the finished texture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			snap_valid_s2 <= 1'b0;
		end else begin
			snap_valid_s2 <= valid_s1 && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && last_s1) begin
			snap_cnt_s2 <= cnt_next;
		end
	end

	assign snap = {snap_valid_s2, snap_cnt_s2};

endmodule

FILE: src/atc_classify.sv
// ratio tests by constant cross-multiplication and the result register
// depends on atc_pkg
module atc_classify import atc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  snap_t      snap,
	output logic       result_valid,
	output logic [1:0] transparency_class
);

	logic [PROD_W-1:0] op_x1000, tot_x999;
	logic [PROD_W-1:0] cl_x4, cp_x3;
	logic [PROD_W-1:0] pa_x20, op_pa_x9;
	logic              opaque_ok, clear_ok, semi_ok;
	logic [1:0]        cls;

	// opaque above 0.999 of total, clear above 0.75 of transparent, semi below 0.45
	always_comb begin
		op_x1000 = PROD_W'(snap.counts.opaque) * PROD_W'(1000);
		tot_x999 = PROD_W'(snap.counts.total) * PROD_W'(999);
		cl_x4    = PROD_W'(snap.counts.clear) * PROD_W'(4);
		cp_x3    = (PROD_W'(snap.counts.clear) + PROD_W'(snap.counts.partial)) * PROD_W'(3);
		pa_x20   = PROD_W'(snap.counts.partial) * PROD_W'(20);
		op_pa_x9 = (PROD_W'(snap.counts.opaque) + PROD_W'(snap.counts.partial)) * PROD_W'(9);
		// a zero denominator makes both sides zero, so the strict test fails
		opaque_ok = op_x1000 > tot_x999;
		clear_ok  = cl_x4 > cp_x3;
		semi_ok   = pa_x20 < op_pa_x9;
		if (opaque_ok)              cls = CLASS_OPAQUE;
		else if (clear_ok && semi_ok) cls = CLASS_BINARY;
		else                        cls = CLASS_VARIED;
	end

	// result strobe, one cycle per beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else begin
			result_valid <= snap.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (snap.valid) begin
			transparency_class <= cls;
		end
	end

endmodule

FILE: src/alpha_transparency_classifier_core.sv
// top level of the alpha transparency classifier: config registers and pipeline
// depends on atc_pkg, atc_count, atc_classify and assert_macros.svh
//
// usage
//   pixels enter on start with pixel_alpha and last_pixel; busy is always low,
//   so a beat is taken whenever start is high, a sustained rate of one per cycle.
//   the rate is set by the counter update loop, a compare and saturating
//   increment that feeds straight back into the counter register.
//   on a beat with last_pixel set, one class beat appears on transparency_class
//   with result_valid high for exactly one cycle, registered through the input
//   register, the counter snapshot and the classification register.
//   the receiver cannot stall; every strobe must be taken in its cycle.
//   other pixels produce no result.
//   thresholds are written over the apb port (opaque at 0x0, transparent at
//   0x4) by the user only while no texture is in flight; the block does not
//   enforce it. writes have no wait states. reset clears all counters and the
//   pipeline and restores thresholds 250 and 5; no clearing pass is needed.
`include "assert_macros.svh"

module alpha_transparency_classifier_core import atc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [ALPHA_W-1:0] pixel_alpha,
	input  logic               last_pixel,
	output logic               result_valid,
	output logic [1:0]         transparency_class,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	logic [ALPHA_W-1:0] opaque_thr_q;
	logic [ALPHA_W-1:0] clear_thr_q;
	logic               wr_en;
	logic               accept;
	snap_t              snap;

	assign busy   = 1'b0;
	assign pready = 1'b1;
	assign accept = start && !busy;
	assign wr_en  = psel && penable && pwrite && pready;

	// threshold registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			opaque_thr_q <= OPAQUE_THR_RESET;
			clear_thr_q  <= CLEAR_THR_RESET;
		end else if (wr_en) begin
			unique case (paddr[2])
				REG_OPAQUE_THR: opaque_thr_q <= pwdata[ALPHA_W-1:0];
				REG_CLEAR_THR:  clear_thr_q  <= pwdata[ALPHA_W-1:0];
				default: ;
			endcase
		end
	end

	// register readback
	always_comb begin
		unique case (paddr[2])
			REG_OPAQUE_THR: prdata = {{(32-ALPHA_W){1'b0}}, opaque_thr_q};
			REG_CLEAR_THR:  prdata = {{(32-ALPHA_W){1'b0}}, clear_thr_q};
			default:        prdata = '0;
		endcase
	end

	atc_count u_count (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.pixel_alpha (pixel_alpha),
		.last_pixel  (last_pixel),
		.opaque_thr  (opaque_thr_q),
		.clear_thr   (clear_thr_q),
		.snap        (snap)
	);

	atc_classify u_classify (
		.clk                (clk),
		.arst_n             (arst_n),
		.snap               (snap),
		.result_valid       (result_valid),
		.transparency_class (transparency_class)
	);

	// every last-pixel beat yields a result, and only those
	`ASSERT_IMPL(a_last_gives_result, accept && last_pixel, ##3 result_valid, "missing result")
	`ASSERT_IMPL(a_result_has_cause, result_valid, $past(start && last_pixel, 3), "stray result")
	`ASSERT_NEXT(a_snap_to_result, snap.valid, result_valid && transparency_class != 2'd3,
		"snapshot did not reach output")

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 100ps
// testbench of alpha_transparency_classifier_core: directed and random textures,
// each class beat checked against a cycle-free predictor of the pixel counters
// depends on atc_pkg and alpha_transparency_classifier_core
module tb_top;
	import atc_pkg::*;

	// accepting edge to class beat
	localparam int LATENCY = 3;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic [ALPHA_W-1:0] pixel_alpha = '0;
	logic               last_pixel = 1'b0;
	logic               result_valid;
	logic [1:0]         transparency_class;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [2:0]         paddr = '0;
	logic [31:0]        pwdata = '0;
	logic [31:0]        prdata;
	logic               pready;

	// predictor state: thresholds and running counts of the current texture
	logic [ALPHA_W-1:0] opq_thr = OPAQUE_THR_RESET;
	logic [ALPHA_W-1:0] clr_thr = CLEAR_THR_RESET;
	logic [CNT_W-1:0]   cnt_opaque = '0;
	logic [CNT_W-1:0]   cnt_clear = '0;
	logic [CNT_W-1:0]   cnt_semi = '0;
	logic [CNT_W-1:0]   cnt_total = '0;

	logic [1:0] pending_class[$];
	logic [1:0] class_want;
	int         err_cnt = 0;
	int         burst_left = 0;
	bit         gaps_on = 1'b1;

	alpha_transparency_classifier_core u_top (
		.clk                (clk),
		.arst_n             (arst_n),
		.start              (start),
		.busy               (busy),
		.pixel_alpha        (pixel_alpha),
		.last_pixel         (last_pixel),
		.result_valid       (result_valid),
		.transparency_class (transparency_class),
		.psel               (psel),
		.penable            (penable),
		.pwrite             (pwrite),
		.paddr              (paddr),
		.pwdata             (pwdata),
		.prdata             (prdata),
		.pready             (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// hard stop, several times the slowest legal run
	initial begin
		#1_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] c);
		return (c == CNT_MAX) ? c : c + 1'b1;
	endfunction

	// ratio tests as exact cross-multiplications; empty denominators fail
	function automatic logic [1:0] grade_texture();
		logic [63:0] op, cl, pa, tot;
		logic        clear_ok, semi_ok;
		op  = 64'(cnt_opaque);
		cl  = 64'(cnt_clear);
		pa  = 64'(cnt_semi);
		tot = 64'(cnt_total);
		if (tot != 0 && op * 1000 > tot * 999)
			return CLASS_OPAQUE;
		clear_ok = (cl + pa) != 0 && cl * 4 > (cl + pa) * 3;
		semi_ok  = (op + pa) != 0 && pa * 20 < (op + pa) * 9;
		return (clear_ok && semi_ok) ? CLASS_BINARY : CLASS_VARIED;
	endfunction

	// update counts for one accepted pixel; close the texture on the last one
	task automatic count_pixel(input logic [ALPHA_W-1:0] a, input logic l);
		logic is_opq, is_clr;
		is_opq = a >= opq_thr;
		is_clr = a <= clr_thr;
		if (is_opq)
			cnt_opaque = bump(cnt_opaque);
		if (is_clr)
			cnt_clear = bump(cnt_clear);
		if (!is_opq && !is_clr)
			cnt_semi = bump(cnt_semi);
		cnt_total = bump(cnt_total);
		if (l) begin
			pending_class = {pending_class, grade_texture()};
			cnt_opaque = '0;
			cnt_clear  = '0;
			cnt_semi   = '0;
			cnt_total  = '0;
		end
	endtask

	// one pixel beat, with random gaps between bursts when enabled
	task automatic send_pixel(input logic [ALPHA_W-1:0] a, input logic l);
		if (gaps_on) begin
			if (burst_left == 0) begin
				start <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
				burst_left = $urandom_range(1, 40);
			end
			burst_left--;
		end
		start       <= 1'b1;
		pixel_alpha <= a;
		last_pixel  <= l;
		@(posedge clk);
		while (busy) @(posedge clk);
		count_pixel(a, l);
	endtask

	// stop sending and wait for every class beat plus pipeline slack
	task automatic drain();
		start <= 1'b0;
		while (pending_class.size() != 0) @(posedge clk);
		repeat (LATENCY + 2) @(posedge clk);
	endtask

	task automatic apb_xfer(input logic wr, input logic idx, input logic [31:0] wdata,
			output logic [31:0] rdata);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= {idx, 2'b00};
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic check_threshold(input logic idx);
		logic [31:0]        rd;
		logic [ALPHA_W-1:0] exp_thr;
		exp_thr = (idx == REG_OPAQUE_THR) ? opq_thr : clr_thr;
		apb_xfer(1'b0, idx, '0, rd);
		if (rd[ALPHA_W-1:0] !== exp_thr) begin
			$error("%s: expected %0d, actual %0d",
				(idx == REG_OPAQUE_THR) ? "opaque_threshold" : "transparent_threshold",
				exp_thr, rd[ALPHA_W-1:0]);
			err_cnt++;
		end
	endtask

	// write a threshold while idle, junk in the upper data bits
	task automatic set_threshold(input logic idx, input logic [ALPHA_W-1:0] thr);
		logic [31:0] wval, rd;
		wval = $urandom();
		wval[ALPHA_W-1:0] = thr;
		drain();
		apb_xfer(1'b1, idx, wval, rd);
		if (idx == REG_OPAQUE_THR)
			opq_thr = thr;
		else
			clr_thr = thr;
		check_threshold(idx);
	endtask

	// texture with given numbers of clear, semi and opaque pixels, shuffled
	task automatic send_mix(input int n_clr, input int n_semi, input int n_opq);
		int left, r;
		logic [ALPHA_W-1:0] a;
		left = n_clr + n_semi + n_opq;
		while (left > 0) begin
			r = $urandom_range(0, left - 1);
			if (r < n_clr) begin
				a = ALPHA_W'($urandom_range(0, int'(clr_thr)));
				n_clr--;
			end else if (r < n_clr + n_semi) begin
				a = ALPHA_W'($urandom_range(int'(clr_thr) + 1, int'(opq_thr) - 1));
				n_semi--;
			end else begin
				a = ALPHA_W'($urandom_range(int'(opq_thr), 255));
				n_opq--;
			end
			left--;
			send_pixel(a, left == 0);
		end
	endtask

	function automatic logic [ALPHA_W-1:0] pick_alpha(input int profile);
		int r;
		r = $urandom_range(0, 99);
		case (profile)
			1: begin
				if (r < 90)
					return ALPHA_W'($urandom_range(int'(opq_thr), 255));
			end
			2: begin
				if (r < 45)
					return ALPHA_W'($urandom_range(0, int'(clr_thr)));
				if (r < 90)
					return ALPHA_W'($urandom_range(int'(opq_thr), 255));
			end
			3: begin
				case ($urandom_range(0, 5))
					0: return 8'd0;
					1: return 8'd255;
					2: return opq_thr;
					3: return opq_thr - 1'b1;
					4: return clr_thr;
					default: return clr_thr + 1'b1;
				endcase
			end
			default: ;
		endcase
		return ALPHA_W'($urandom_range(0, 255));
	endfunction

	task automatic test_reset_values();
		check_threshold(REG_OPAQUE_THR);
		check_threshold(REG_CLEAR_THR);
	endtask

	// one-pixel textures around both default thresholds
	task automatic test_single_pixel();
		send_pixel(8'd0, 1'b1);
		send_pixel(8'd5, 1'b1);
		send_pixel(8'd6, 1'b1);
		send_pixel(8'd128, 1'b1);
		send_pixel(8'd249, 1'b1);
		send_pixel(8'd250, 1'b1);
		send_pixel(8'd255, 1'b1);
	endtask

	// binary cutout edges, an all-semi texture, then opaque pixels with and without a semi pixel
	task automatic test_class_boundaries();
		send_mix(3, 0, 1);
		send_mix(3, 1, 0);
		send_mix(4, 1, 2);
		send_mix(4, 1, 1);
		send_mix(0, 5, 0);
		send_mix(0, 1, 9);
		send_mix(0, 0, 12);
		drain();
	endtask

	// widest, narrowest and overlapping threshold windows
	task automatic test_threshold_extremes();
		set_threshold(REG_OPAQUE_THR, 8'd0);
		set_threshold(REG_CLEAR_THR, 8'd255);
		send_pixel(8'd0, 1'b0);
		send_pixel(8'd255, 1'b0);
		send_pixel(8'd128, 1'b1);
		send_pixel(8'd77, 1'b1);
		set_threshold(REG_OPAQUE_THR, 8'd255);
		set_threshold(REG_CLEAR_THR, 8'd0);
		send_pixel(8'd0, 1'b0);
		send_pixel(8'd1, 1'b0);
		send_pixel(8'd254, 1'b0);
		send_pixel(8'd255, 1'b1);
		send_pixel(8'd0, 1'b1);
		set_threshold(REG_OPAQUE_THR, 8'd100);
		set_threshold(REG_CLEAR_THR, 8'd200);
		send_pixel(8'd150, 1'b0);
		send_pixel(8'd50, 1'b0);
		send_pixel(8'd250, 1'b1);
		send_pixel(8'd150, 1'b1);
	endtask

	// random thresholds per phase, textures of random length and make-up
	task automatic test_random_textures();
		int len, profile, sent;
		for (int ph = 0; ph < 6; ph++) begin
			if (ph == 4) begin
				set_threshold(REG_OPAQUE_THR, ALPHA_W'($urandom_range(0, 255)));
				set_threshold(REG_CLEAR_THR, ALPHA_W'($urandom_range(0, 255)));
			end else begin
				set_threshold(REG_OPAQUE_THR, ALPHA_W'($urandom_range(128, 255)));
				set_threshold(REG_CLEAR_THR, ALPHA_W'($urandom_range(0, 127)));
			end
			gaps_on = (ph != 2);
			sent = 0;
			while (sent < 65) begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
					: $urandom_range(1, 20);
				profile = $urandom_range(0, 3);
				for (int i = 0; i < len; i++) begin
					// occasional early end marker cuts the texture short
					send_pixel(pick_alpha(profile),
						(i == len - 1) || ($urandom_range(0, 49) == 0));
				end
				sent += len;
			end
		end
		gaps_on = 1'b1;
	endtask

	// back-to-back opaque and semi pixels, then counters must restart from zero
	task automatic test_counter_restart();
		set_threshold(REG_OPAQUE_THR, OPAQUE_THR_RESET);
		set_threshold(REG_CLEAR_THR, CLEAR_THR_RESET);
		gaps_on = 1'b0;
		for (int i = 0; i < 40; i++)
			send_pixel(ALPHA_W'($urandom_range(250, 255)), 1'b0);
		for (int i = 0; i < 10; i++)
			send_pixel(ALPHA_W'($urandom_range(6, 249)), i == 9);
		send_pixel(8'd128, 1'b1);
		gaps_on = 1'b1;
	endtask

	// class beat check against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && result_valid) begin
			if (pending_class.size() == 0) begin
				$error("transparency_class: expected none, actual %0d", transparency_class);
				err_cnt++;
			end else begin
				class_want = pending_class.pop_front();
				if (transparency_class !== class_want) begin
					$error("transparency_class: expected %0d, actual %0d",
						class_want, transparency_class);
					err_cnt++;
				end
			end
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_values();
		test_single_pixel();
		test_class_boundaries();
		test_threshold_extremes();
		test_random_textures();
		test_counter_restart();
		drain();
		if (err_cnt == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

FILE: files.f
+incdir+src
src/atc_pkg.sv
src/atc_count.sv
src/atc_classify.sv
src/alpha_transparency_classifier_core.sv
test/tb_top.sv
